@@ hw/rtl/lgn_pkg.sv @@
// Shared types and constants of the loudness gain normaliser.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package lgn_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int LINEAR_FRAC_BITS = 16;

    localparam int GAIN_W     = 16;
    localparam int LOUD_W     = 16;
    localparam int TARGET_W   = 15;
    localparam int FLOOR_W    = 16;
    localparam int STEP_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TARGET_LOUDNESS,
        CFG_SILENCE_FLOOR,
        CFG_RAMP_UP_STEP,
        CFG_RAMP_DOWN_STEP
    } cfg_index_t;

    localparam logic signed [TARGET_W-1:0] TARGET_LOUDNESS_RST = -15'sd4608;
    localparam logic signed [FLOOR_W-1:0]  SILENCE_FLOOR_RST   = -16'sd17920;
    localparam logic [STEP_W-1:0]          RAMP_UP_RST         = 8'd8;
    localparam logic [STEP_W-1:0]          RAMP_DOWN_RST       = 8'd1;

    localparam logic [1:0] ACT_SAMPLE    = 2'd0;
    localparam logic [1:0] ACT_MOMENTARY = 2'd1;
    localparam logic [1:0] ACT_SHORTTERM = 2'd2;

    // Exponent scale log2(10)/5120 and ln(2), both in Q32.
    localparam logic [37:0] EXP_SCALE_Q32 = 38'd2786635;
    localparam logic [31:0] LN2_Q32       = 32'd2977044472;
    localparam int          TAYLOR_TERMS  = 14;

    localparam int EXP_N_MAX = 21;
    localparam int LIN_W     = 33 + EXP_N_MAX + LINEAR_FRAC_BITS - 32;
    localparam int LIN_LO_W  = LIN_W / 2;
    localparam int LIN_HI_W  = LIN_W - LIN_LO_W;
    localparam int MAG_W     = SAMPLE_BITS;
    localparam int PLO_W     = MAG_W + LIN_LO_W;
    localparam int PROD_W    = MAG_W + LIN_W;

    localparam logic [PROD_W:0] ROUND_HALF =
        (PROD_W + 1)'(1) << (LINEAR_FRAC_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] SAT_POS = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_NEG = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0]                     action;
        logic signed [SAMPLE_BITS-1:0]  sample_in;
        logic                           frame_end;
        logic signed [LOUD_W-1:0]       loudness;
        logic                           loudness_valid;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0]  sample_out;
        logic                           frame_end_out;
        logic signed [GAIN_W-1:0]       gain_applied;
    } out_item_t;

    typedef enum logic {
        CMD_SAMPLE,
        CMD_TARGET
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic                     frame_end;
        logic [SAMPLE_BITS-1:0]   data;
    } cmd_t;

    typedef struct packed {
        logic                     start;
        logic signed [GAIN_W-1:0] gain;
    } conv_req_t;

    typedef struct packed {
        logic                     done;
        logic [LIN_W-1:0]         lin;
    } conv_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/loudness_gain_normalizer.sv @@
// Loudness gain normaliser: samples go via the command queue and the back's S_MUL_LO, S_MUL_HI
// and S_ROUND states to the output register. The back takes samples one at a time, and one
// gain update per cycle while idle with a converted gain. After a frame end that moves the
// gain, samples wait for the Taylor-series converter, which runs each of its 13 terms through
// multiply, divide and fix-up states. Reset clears all gains to unity and loads the register
// defaults; the four-entry queue takes in transfers during the first conversion.
`default_nettype none

module loudness_gain_normalizer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire lgn_pkg::in_item_t                  in_data,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output lgn_pkg::out_item_t                      out_data,
    input  wire logic                               cfg_write,
    input  wire logic [lgn_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [lgn_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic signed [lgn_pkg::TARGET_W-1:0] target_loudness_reg;
    logic signed [lgn_pkg::FLOOR_W-1:0]  silence_floor_reg;
    logic [lgn_pkg::STEP_W-1:0]          ramp_up_reg;
    logic [lgn_pkg::STEP_W-1:0]          ramp_down_reg;

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    lgn_pkg::cmd_t q_push_cmd;
    lgn_pkg::cmd_t q_pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_loudness_reg <= lgn_pkg::TARGET_LOUDNESS_RST;
            silence_floor_reg   <= lgn_pkg::SILENCE_FLOOR_RST;
            ramp_up_reg         <= lgn_pkg::RAMP_UP_RST;
            ramp_down_reg       <= lgn_pkg::RAMP_DOWN_RST;
        end
        else if (cfg_write)
        begin
            unique case (lgn_pkg::cfg_index_t'(cfg_index))
                lgn_pkg::CFG_TARGET_LOUDNESS:
                begin
                    target_loudness_reg <= cfg_data[lgn_pkg::TARGET_W-1:0];
                end
                lgn_pkg::CFG_SILENCE_FLOOR:
                begin
                    silence_floor_reg <= cfg_data[lgn_pkg::FLOOR_W-1:0];
                end
                lgn_pkg::CFG_RAMP_UP_STEP:
                begin
                    ramp_up_reg <= cfg_data[lgn_pkg::STEP_W-1:0];
                end
                lgn_pkg::CFG_RAMP_DOWN_STEP:
                begin
                    ramp_down_reg <= cfg_data[lgn_pkg::STEP_W-1:0];
                end
                default:
                begin
                    ramp_down_reg <= ramp_down_reg;
                end
            endcase
        end
    end

    lgn_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .target_loudness (target_loudness_reg),
        .silence_floor   (silence_floor_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_cmd           (q_push_cmd)
    );

    lgn_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .empty    (q_empty)
    );

    lgn_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_cmd          (q_pop_cmd),
        .q_pop          (q_pop),
        .ramp_up_step   (ramp_up_reg),
        .ramp_down_step (ramp_down_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data)
    );

endmodule

`default_nettype wire

@@ hw/rtl/lgn_queue.sv @@
// Short command queue between the front and the back of the gain normaliser.
// Depends on lgn_pkg.
`default_nettype none

module lgn_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lgn_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output lgn_pkg::cmd_t      pop_cmd,
    output logic               empty
);

    lgn_pkg::cmd_t                 entries_reg [lgn_pkg::QUEUE_DEPTH];
    logic [lgn_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [lgn_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [lgn_pkg::QPTR_W:0]      count_reg;

    assign full    = (count_reg == (lgn_pkg::QPTR_W + 1)'(lgn_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entries_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("Queue written while full.");
    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("Queue read while empty.");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (lgn_pkg::QPTR_W + 1)'(lgn_pkg::QUEUE_DEPTH))
        else $error("Queue fill count beyond its depth.");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/lgn_front.sv @@
// Front of the gain normaliser: takes input transfers, blends loudness into gains.
// Samples and new target gains go on to the command queue. Depends on lgn_pkg.
`default_nettype none

module lgn_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire lgn_pkg::in_item_t                     in_data,
    input  wire logic signed [lgn_pkg::TARGET_W-1:0]   target_loudness,
    input  wire logic signed [lgn_pkg::FLOOR_W-1:0]    silence_floor,
    input  wire logic                                  q_full,
    output logic                                       q_push,
    output lgn_pkg::cmd_t                              q_cmd
);

    localparam int GW = lgn_pkg::GAIN_W;

    logic signed [GW-1:0] momentary_reg;
    logic signed [GW-1:0] shortterm_reg;
    logic signed [GW-1:0] momentary_next;
    logic signed [GW-1:0] shortterm_next;

    logic                 accept;
    logic                 quiet;
    logic signed [GW:0]   diff;
    logic signed [GW-1:0] wanted;
    logic signed [GW+1:0] m_sum;
    logic signed [GW:0]   s_sum;
    logic signed [GW:0]   t_sum;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        quiet = !in_data.loudness_valid || (in_data.loudness < silence_floor);
        diff  = (GW + 1)'(target_loudness) - (GW + 1)'(in_data.loudness);
        priority if (quiet)
        begin
            wanted = '0;
        end
        else if (diff > (GW + 1)'(signed'(16'sh7FFF)))
        begin
            wanted = 16'sh7FFF;
        end
        else if (diff < (GW + 1)'(signed'(-16'sh8000)))
        begin
            wanted = -16'sh8000;
        end
        else
        begin
            wanted = diff[GW-1:0];
        end

        m_sum = ((GW + 2)'(momentary_reg) <<< 1) + (GW + 2)'(momentary_reg)
                + (GW + 2)'(wanted);
        s_sum = (GW + 1)'(shortterm_reg) + (GW + 1)'(wanted);

        momentary_next = momentary_reg;
        shortterm_next = shortterm_reg;
        q_push         = 1'b0;
        q_cmd.kind     = lgn_pkg::CMD_SAMPLE;
        q_cmd.frame_end = in_data.frame_end;
        q_cmd.data     = in_data.sample_in;

        unique case (in_data.action)
            lgn_pkg::ACT_SAMPLE:
            begin
                q_push = accept;
            end
            lgn_pkg::ACT_MOMENTARY:
            begin
                momentary_next = m_sum[GW+1:2];
                q_push         = accept;
                q_cmd.kind     = lgn_pkg::CMD_TARGET;
            end
            lgn_pkg::ACT_SHORTTERM:
            begin
                shortterm_next = s_sum[GW:1];
                q_push         = accept;
                q_cmd.kind     = lgn_pkg::CMD_TARGET;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase

        t_sum = (GW + 1)'(momentary_next) + (GW + 1)'(shortterm_next);
        if (q_cmd.kind == lgn_pkg::CMD_TARGET)
        begin
            q_cmd.data = lgn_pkg::SAMPLE_BITS'(t_sum[GW:1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            momentary_reg <= '0;
            shortterm_reg <= '0;
        end
        else if (accept)
        begin
            momentary_reg <= momentary_next;
            shortterm_reg <= shortterm_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lgn_db2lin.sv @@
// Gain converter: 1/256 dB gain to a linear factor, one Taylor term at a time.
// The terms share its 32 by 32 multipliers. Depends on lgn_pkg.
`default_nettype none

module lgn_db2lin (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire lgn_pkg::conv_req_t  req,
    output lgn_pkg::conv_rsp_t       rsp
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_FRAC,
        C_MUL,
        C_DIV,
        C_FIX,
        C_SHIFT
    } conv_state_t;

    conv_state_t               state_reg;
    logic signed [37:0]        e_reg;
    logic signed [5:0]         n_reg;
    logic [31:0]               x_reg;
    logic [31:0]               term_reg;
    logic [31:0]               v_reg;
    logic [31:0]               q0_reg;
    logic [32:0]               sum_reg;
    logic [3:0]                k_reg;
    logic                      done_reg;
    logic [lgn_pkg::LIN_W-1:0] lin_reg;

    logic [63:0]               frac_prod;
    logic [63:0]               term_prod;
    logic [63:0]               div_prod;
    logic [35:0]               rem;
    logic [31:0]               quot;
    logic signed [7:0]         sh;
    logic [33:0]               rnd;
    logic [lgn_pkg::LIN_W-1:0] lin_next;

    function automatic logic [31:0] recip_q32(input logic [3:0] k);
        logic [31:0] r;
        unique case (k)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            4'd13:   r = 32'd330382099;
            4'd14:   r = 32'd306783378;
            default: r = '0;
        endcase
        return r;
    endfunction

    assign rsp.done = done_reg;
    assign rsp.lin  = lin_reg;

    always_comb
    begin
        frac_prod = 64'(e_reg[31:0]) * 64'(lgn_pkg::LN2_Q32);
        term_prod = 64'(term_reg) * 64'(x_reg);
        div_prod  = 64'(v_reg) * 64'(recip_q32(k_reg));
        rem       = 36'(v_reg) - 36'(q0_reg) * 36'(k_reg);
        quot      = (rem >= 36'(k_reg)) ? q0_reg + 32'd1 : q0_reg;

        // The reciprocal estimate is at most one below the true quotient.
        sh  = 8'(n_reg) + 8'(lgn_pkg::LINEAR_FRAC_BITS) - 8'd32;
        rnd = (34'(sum_reg >> unsigned'(~sh)) + 34'd1) >> 1;
        if (!sh[7])
        begin
            lin_next = lgn_pkg::LIN_W'(sum_reg) << unsigned'(sh[6:0]);
        end
        else
        begin
            lin_next = lgn_pkg::LIN_W'(rnd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == C_SHIFT);
            unique case (state_reg)
                C_IDLE:
                begin
                    if (req.start)
                    begin
                        e_reg     <= 38'(req.gain) * lgn_pkg::EXP_SCALE_Q32;
                        state_reg <= C_FRAC;
                    end
                end
                C_FRAC:
                begin
                    n_reg     <= e_reg[37:32];
                    x_reg     <= frac_prod[63:32];
                    term_reg  <= frac_prod[63:32];
                    sum_reg   <= {1'b1, frac_prod[63:32]};
                    k_reg     <= 4'd2;
                    state_reg <= C_MUL;
                end
                C_MUL:
                begin
                    v_reg     <= term_prod[63:32];
                    state_reg <= C_DIV;
                end
                C_DIV:
                begin
                    q0_reg    <= div_prod[63:32];
                    state_reg <= C_FIX;
                end
                C_FIX:
                begin
                    term_reg <= quot;
                    sum_reg  <= sum_reg + 33'(quot);
                    if (k_reg == 4'(lgn_pkg::TAYLOR_TERMS))
                    begin
                        state_reg <= C_SHIFT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= C_MUL;
                    end
                end
                C_SHIFT:
                begin
                    lin_reg   <= lin_next;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lgn_back.sv @@
// Back of the gain normaliser: applies the linear gain to samples and ramps the gain.
// Holds the output register. Depends on lgn_pkg and lgn_db2lin.
`default_nettype none

module lgn_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              q_empty,
    input  wire lgn_pkg::cmd_t                     q_cmd,
    output logic                                   q_pop,
    input  wire logic [lgn_pkg::STEP_W-1:0]        ramp_up_step,
    input  wire logic [lgn_pkg::STEP_W-1:0]        ramp_down_step,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output lgn_pkg::out_item_t                     out_data
);

    localparam int GW = lgn_pkg::GAIN_W;
    localparam int SB = lgn_pkg::SAMPLE_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_MUL_LO,
        S_MUL_HI,
        S_ROUND
    } back_state_t;

    back_state_t                  state_reg;
    logic                         lin_ok_reg;
    logic signed [GW-1:0]         target_reg;
    logic signed [GW-1:0]         current_reg;
    logic [lgn_pkg::MAG_W-1:0]    mag_reg;
    logic                         neg_reg;
    logic                         fe_reg;
    logic [lgn_pkg::PLO_W-1:0]    plo_reg;
    logic [lgn_pkg::PROD_W-1:0]   prod_reg;
    logic                         out_valid_reg;
    lgn_pkg::out_item_t           out_data_reg;

    lgn_pkg::conv_req_t           conv_req;
    lgn_pkg::conv_rsp_t           conv_rsp;

    logic [SB-1:0]                raw;
    logic                         raw_neg;
    logic [lgn_pkg::MAG_W-1:0]    raw_mag;
    logic [lgn_pkg::PROD_W:0]     rounded;
    logic [lgn_pkg::PROD_W:0]     r_wide;
    logic [SB-1:0]                lim;
    logic [SB-1:0]                r_mag;
    lgn_pkg::out_item_t           result;
    logic signed [GW:0]           cur_w;
    logic signed [GW:0]           tgt_w;
    logic signed [GW:0]           up_w;
    logic signed [GW:0]           dn_w;
    logic signed [GW-1:0]         ramped;

    lgn_db2lin u_db2lin (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (conv_req),
        .rsp   (conv_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        conv_req.start = (state_reg == S_IDLE) && !lin_ok_reg;
        conv_req.gain  = current_reg;
        q_pop          = (state_reg == S_IDLE) && lin_ok_reg && !q_empty;

        raw     = q_cmd.data;
        raw_neg = raw[SB-1];
        raw_mag = raw_neg ? (~raw + SB'(1)) : raw;

        rounded = {1'b0, prod_reg} + lgn_pkg::ROUND_HALF;
        r_wide  = rounded >> lgn_pkg::LINEAR_FRAC_BITS;
        lim     = neg_reg ? lgn_pkg::SAT_NEG : lgn_pkg::SAT_POS;
        r_mag   = (r_wide > (lgn_pkg::PROD_W + 1)'(lim)) ? lim : r_wide[SB-1:0];
        result.sample_out    = neg_reg ? (~r_mag + SB'(1)) : r_mag;
        result.frame_end_out = fe_reg;
        result.gain_applied  = current_reg;

        cur_w = (GW + 1)'(current_reg);
        tgt_w = (GW + 1)'(target_reg);
        up_w  = cur_w + (GW + 1)'(ramp_up_step);
        dn_w  = cur_w - (GW + 1)'(ramp_down_step);
        priority if (current_reg < target_reg)
        begin
            ramped = (up_w > tgt_w) ? target_reg : up_w[GW-1:0];
        end
        else if (current_reg > target_reg)
        begin
            ramped = (dn_w < tgt_w) ? target_reg : dn_w[GW-1:0];
        end
        else
        begin
            ramped = current_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lin_ok_reg    <= 1'b0;
            target_reg    <= '0;
            current_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != S_ROUND))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!lin_ok_reg)
                    begin
                        state_reg <= S_CONV;
                    end
                    else if (!q_empty)
                    begin
                        if (q_cmd.kind == lgn_pkg::CMD_TARGET)
                        begin
                            target_reg <= q_cmd.data[GW-1:0];
                        end
                        else
                        begin
                            mag_reg   <= raw_mag;
                            neg_reg   <= raw_neg;
                            fe_reg    <= q_cmd.frame_end;
                            state_reg <= S_MUL_LO;
                        end
                    end
                end
                S_CONV:
                begin
                    if (conv_rsp.done)
                    begin
                        lin_ok_reg <= 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                S_MUL_LO:
                begin
                    plo_reg   <= lgn_pkg::PLO_W'(mag_reg)
                                 * lgn_pkg::PLO_W'(conv_rsp.lin[lgn_pkg::LIN_LO_W-1:0]);
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    prod_reg  <= lgn_pkg::PROD_W'(plo_reg)
                                 + ((lgn_pkg::PROD_W'(mag_reg)
                                    * lgn_pkg::PROD_W'(conv_rsp.lin[lgn_pkg::LIN_W-1:lgn_pkg::LIN_LO_W]))
                                    << lgn_pkg::LIN_LO_W);
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= result;
                        if (fe_reg)
                        begin
                            current_reg <= ramped;
                            if (ramped != current_reg)
                            begin
                                lin_ok_reg <= 1'b0;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_mul_has_lin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_LO) |-> lin_ok_reg)
        else $error("Sample multiplied without a converted gain.");
    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_rsp.done |-> (state_reg == S_CONV))
        else $error("Conversion finished while no conversion was awaited.");
    a_gain_at_round: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(current_reg) |-> ($past(state_reg) == S_ROUND))
        else $error("Gain changed outside the sample output stage.");
`endif

endmodule

`default_nettype wire

@@ dv/loudness_gain_normalizer_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the loudness gain normaliser: directed and random transfers,
// predicted in step with the block and compared field by field. Depends on lgn_pkg and the
// loudness_gain_normalizer module only.

module loudness_gain_normalizer_tb;
    import lgn_pkg::*;

    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int PHASE_ITEMS   = 115;
    localparam int PHASE_COUNT   = 6;
    localparam int MAX_PRINTS    = 60;

    localparam logic [1:0]  ACT_UNUSED   = 2'd3;
    localparam longint      LOG2_10_STEP = 64'sd2786635;
    localparam logic [63:0] LN2_FRAC     = 64'd2977044472;
    localparam int          EXP_TERMS    = 14;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int target_lu = -4608;
    int floor_lu  = -17920;
    int step_up   = 8;
    int step_down = 1;

    int mom_gain = 0;
    int st_gain  = 0;
    int tgt_gain = 0;
    int cur_gain = 0;

    in_item_t  pending_items[$];
    out_item_t expected_samples[$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int frame_channels = 2;
    int channel_pos    = 0;

    loudness_gain_normalizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp16(input int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic logic [63:0] gain_to_factor(input int gain);
        longint      expo;
        longint      whole;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        int          sh;
        int          k;
        expo  = longint'(gain) * LOG2_10_STEP;
        whole = expo >>> 32;
        frac  = {32'd0, expo[31:0]};
        x     = (frac * LN2_FRAC) >> 32;
        term  = 64'd1 << 32;
        acc   = term;
        for (k = 1; k <= EXP_TERMS; k++)
        begin
            term = ((term * x) >> 32) / 64'(k);
            acc  = acc + term;
        end
        sh = int'(whole) + LINEAR_FRAC_BITS - 32;
        if (sh >= 0)
        begin
            return acc << sh;
        end
        sh = -sh;
        return (acc + (64'd1 << (sh - 1))) >> sh;
    endfunction

    task automatic advance_gain_model(input in_item_t item);
        int          lu;
        int          wanted;
        longint      s;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] lim;
        logic [63:0] r;
        out_item_t   res;
        if (item.action == ACT_MOMENTARY || item.action == ACT_SHORTTERM)
        begin
            lu     = $signed(item.loudness);
            wanted = (!item.loudness_valid || lu < floor_lu) ? 0 : clamp16(target_lu - lu);
            if (item.action == ACT_MOMENTARY)
            begin
                mom_gain = (wanted + 3 * mom_gain) >>> 2;
            end
            else
            begin
                st_gain = (wanted + st_gain) >>> 1;
            end
            tgt_gain = (mom_gain + st_gain) >>> 1;
        end
        else if (item.action == ACT_SAMPLE)
        begin
            s    = $signed(item.sample_in);
            mag  = (s < 0) ? 64'(-s) : 64'(s);
            prod = mag * gain_to_factor(cur_gain);
            r    = (prod + (64'd1 << (LINEAR_FRAC_BITS - 1))) >> LINEAR_FRAC_BITS;
            lim  = (s < 0) ? (64'd1 << (SAMPLE_BITS - 1)) : (64'd1 << (SAMPLE_BITS - 1)) - 1;
            if (r > lim)
            begin
                r = lim;
            end
            if (s < 0)
            begin
                r = -r;
            end
            res.sample_out    = r[SAMPLE_BITS-1:0];
            res.frame_end_out = item.frame_end;
            res.gain_applied  = cur_gain[GAIN_W-1:0];
            expected_samples.push_back(res);
            if (item.frame_end)
            begin
                if (cur_gain < tgt_gain)
                begin
                    cur_gain = cur_gain + step_up;
                    if (cur_gain > tgt_gain)
                    begin
                        cur_gain = tgt_gain;
                    end
                end
                else if (cur_gain > tgt_gain)
                begin
                    cur_gain = cur_gain - step_down;
                    if (cur_gain < tgt_gain)
                    begin
                        cur_gain = tgt_gain;
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
        begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
        mismatch_count++;
    endtask

    task automatic check_sample(input out_item_t got);
        out_item_t want;
        if (expected_samples.size() == 0)
        begin
            report_mismatch($sformatf("output transfer with nothing expected, sample_out %0d",
                                      got.sample_out));
            return;
        end
        want = expected_samples.pop_front();
        if (got.sample_out !== want.sample_out)
        begin
            report_mismatch($sformatf("sample_out %0d, expected %0d",
                                      got.sample_out, want.sample_out));
        end
        if (got.frame_end_out !== want.frame_end_out)
        begin
            report_mismatch($sformatf("frame_end_out %0b, expected %0b",
                                      got.frame_end_out, want.frame_end_out));
        end
        if (got.gain_applied !== want.gain_applied)
        begin
            report_mismatch($sformatf("gain_applied %0d, expected %0d",
                                      got.gain_applied, want.gain_applied));
        end
    endtask

    // Input side: a new transfer is offered only once the previous one has been taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_gain_model(in_data);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_sample(out_data);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic in_item_t make_item(input logic [1:0] act, input int sample,
                                           input logic fe, input int loud, input logic valid);
        in_item_t it;
        it.action         = act;
        it.sample_in      = sample[SAMPLE_BITS-1:0];
        it.frame_end      = fe;
        it.loudness       = loud[LOUD_W-1:0];
        it.loudness_valid = valid;
        return it;
    endfunction

    function automatic int random_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            return int'($urandom);
        end
        if (pick < 85)
        begin
            return int'($urandom_range(4096)) - 2048;
        end
        case ($urandom_range(3))
            0:       return 8388607;
            1:       return -8388608;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    function automatic int random_loudness();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)
        begin
            return -int'($urandom_range(12800, 768));
        end
        if (pick < 80)
        begin
            return clamp16(floor_lu + int'($urandom_range(512)) - 256);
        end
        if (pick < 92)
        begin
            return int'($urandom);
        end
        case ($urandom_range(3))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return -1;
        endcase
    endfunction

    // Mostly whole frames with loudness updates in between; the rest are stray samples and
    // unused action codes.
    task automatic queue_random_items(input int count);
        int       queued;
        int       pick;
        logic     last;
        in_item_t it;
        queued         = 0;
        frame_channels = $urandom_range(4, 1);
        channel_pos    = 0;
        while (queued < count)
        begin
            pick = $urandom_range(99);
            if (pick < 62)
            begin
                last        = (channel_pos == frame_channels - 1);
                it          = make_item(ACT_SAMPLE, random_sample(), last, random_loudness(),
                                        1'($urandom));
                channel_pos = last ? 0 : channel_pos + 1;
            end
            else if (pick < 76)
            begin
                it = make_item(ACT_MOMENTARY, random_sample(), 1'($urandom), random_loudness(),
                               $urandom_range(99) < 90);
            end
            else if (pick < 88)
            begin
                it = make_item(ACT_SHORTTERM, random_sample(), 1'($urandom), random_loudness(),
                               $urandom_range(99) < 90);
            end
            else if (pick < 92)
            begin
                it = make_item(ACT_UNUSED, random_sample(), 1'($urandom), random_loudness(),
                               1'($urandom));
            end
            else
            begin
                it = make_item(ACT_SAMPLE, random_sample(), 1'($urandom), random_loudness(),
                               1'($urandom));
            end
            pending_items.push_back(it);
            if (it.action != ACT_UNUSED)
            begin
                queued++;
            end
        end
    endtask

    task automatic set_config(input int tl, input int fl, input int up, input int dn);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_TARGET_LOUDNESS;
        cfg_data  <= 16'(tl);
        @(posedge clk);
        cfg_index <= CFG_SILENCE_FLOOR;
        cfg_data  <= 16'(fl);
        @(posedge clk);
        cfg_index <= CFG_RAMP_UP_STEP;
        cfg_data  <= 16'(up);
        @(posedge clk);
        cfg_index <= CFG_RAMP_DOWN_STEP;
        cfg_data  <= 16'(dn);
        @(posedge clk);
        cfg_write <= 1'b0;
        target_lu = tl;
        floor_lu  = fl;
        step_up   = up;
        step_down = dn;
    endtask

    // Loudness transfers give no output, so a fixed settling time follows the last sample.
    task automatic wait_idle();
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        pending_items.push_back(make_item(ACT_SAMPLE, 8388607, 1'b0, 0, 1'b0));
        pending_items.push_back(make_item(ACT_SAMPLE, -8388608, 1'b0, 0, 1'b0));
        pending_items.push_back(make_item(ACT_SAMPLE, 0, 1'b1, 0, 1'b0));
        pending_items.push_back(make_item(ACT_SAMPLE, -1, 1'b0, 0, 1'b0));
        pending_items.push_back(make_item(ACT_UNUSED, 12345, 1'b1, -100, 1'b1));
        pending_items.push_back(make_item(ACT_MOMENTARY, 77, 1'b1, -7680, 1'b1));
        pending_items.push_back(make_item(ACT_SHORTTERM, -77, 1'b0, -7680, 1'b1));
        pending_items.push_back(make_item(ACT_MOMENTARY, 0, 1'b0, -7680, 1'b0));
        pending_items.push_back(make_item(ACT_SHORTTERM, 0, 1'b0, -32768, 1'b1));
        pending_items.push_back(make_item(ACT_MOMENTARY, 0, 1'b0, 32767, 1'b1));
        pending_items.push_back(make_item(ACT_SHORTTERM, 0, 1'b0, -17920, 1'b1));
        pending_items.push_back(make_item(ACT_MOMENTARY, 0, 1'b0, -17921, 1'b1));
        pending_items.push_back(make_item(ACT_SAMPLE, 8388607, 1'b1, 0, 1'b0));
        pending_items.push_back(make_item(ACT_SAMPLE, -8388608, 1'b1, 0, 1'b0));
        pending_items.push_back(make_item(ACT_SAMPLE, 4096, 1'b1, 0, 1'b0));
        pending_items.push_back(make_item(ACT_SAMPLE, -4096, 1'b0, 32767, 1'b0));
        wait_idle();

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: set_config(0, -32768, 255, 255);
                1: set_config(-16384, 0, 0, 0);
                4: set_config(TARGET_LOUDNESS_RST, SILENCE_FLOOR_RST, RAMP_UP_RST, RAMP_DOWN_RST);
                default: set_config(-int'($urandom_range(16384)), -int'($urandom_range(32768)),
                                    $urandom_range(255), $urandom_range(255));
            endcase
            @(negedge clk);
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            if (phase == 0)
            begin
                pending_items.push_back(make_item(ACT_MOMENTARY, 0, 1'b0, -32768, 1'b1));
                pending_items.push_back(make_item(ACT_SHORTTERM, 0, 1'b0, -32768, 1'b1));
                pending_items.push_back(make_item(ACT_SHORTTERM, 0, 1'b0, 32767, 1'b0));
                pending_items.push_back(make_item(ACT_SAMPLE, 8388607, 1'b1, 0, 1'b0));
                pending_items.push_back(make_item(ACT_SAMPLE, -8388608, 1'b1, 0, 1'b0));
                pending_items.push_back(make_item(ACT_SAMPLE, 2048, 1'b1, 0, 1'b0));
                pending_items.push_back(make_item(ACT_SAMPLE, -2048, 1'b1, 0, 1'b0));
                pending_items.push_back(make_item(ACT_SAMPLE, 1, 1'b1, 0, 1'b0));
                pending_items.push_back(make_item(ACT_SAMPLE, 0, 1'b1, 0, 1'b0));
                pending_items.push_back(make_item(ACT_SAMPLE, 3000000, 1'b1, 0, 1'b0));
            end
            queue_random_items(PHASE_ITEMS);
            wait_idle();
        end

        if (expected_samples.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected outputs never arrived",
                                      expected_samples.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
